// ===== rtl/core/mvt_pkg.sv =====
// shared types, widths and constants for the 4x4 matrix vector transform
package mvt_pkg;

    localparam int MVT_WORD_BITS = 32;
    localparam int MVT_FRAC_BITS = 16;
    localparam int MVT_DIM       = 4;
    localparam int MVT_ELEMS     = MVT_DIM * MVT_DIM;
    localparam int MVT_IDX_BITS  = $clog2(MVT_DIM);
    localparam int MVT_PROD_BITS = 2 * MVT_WORD_BITS;
    localparam int MVT_PAIR_BITS = MVT_PROD_BITS + 1;
    localparam int MVT_SUM_BITS  = MVT_PROD_BITS + 2;

    typedef logic signed [MVT_WORD_BITS-1:0] mvt_word_t;
    typedef logic signed [MVT_PROD_BITS-1:0] mvt_prod_t;
    typedef logic signed [MVT_PAIR_BITS-1:0] mvt_pair_t;
    typedef logic signed [MVT_SUM_BITS-1:0]  mvt_sum_t;
    typedef logic [MVT_IDX_BITS-1:0]         mvt_idx_t;

    localparam mvt_word_t MVT_WORD_MAX = {1'b0, {(MVT_WORD_BITS-1){1'b1}}};
    localparam mvt_word_t MVT_WORD_MIN = {1'b1, {(MVT_WORD_BITS-1){1'b0}}};

    typedef enum logic {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } mvt_op_t;

    typedef struct packed {
        mvt_op_t   operation;
        mvt_idx_t  col_index;
        mvt_idx_t  row_index;
        mvt_word_t element_value;
        mvt_word_t vec_x;
        mvt_word_t vec_y;
        mvt_word_t vec_z;
        mvt_word_t vec_w;
    } mvt_in_word_t;

    typedef struct packed {
        mvt_word_t out_x;
        mvt_word_t out_y;
        mvt_word_t out_z;
        mvt_word_t out_w;
        logic      saturated;
    } mvt_out_word_t;

    typedef struct packed {
        logic prod_en;
        logic pair_en;
        logic out_en;
    } mvt_pipe_ctl_t;

endpackage

// ===== rtl/core/matrix4_vector_transform.sv =====
// top level of the 4x4 matrix times vector transform
// holds a column-major 4x4 matrix of signed Q16.16 words (cleared on reset)
// and streams vectors through it: a load word writes one element and gives
// no result; a transform word gives one result word, M * v, each row being
// the exact sum of four products shifted right by FRAC_BITS (rounding toward
// minus infinity) and saturated to 32 bits, with saturated set when any row
// clipped. one word of either kind is taken every cycle unless a waiting
// result has filled the pipeline; a transform moves through the product
// stage of sixteen 32x32 multipliers in four row lanes, a pair-sum stage
// and the merging stage. a load takes effect for the very next transform word.
// empty pipeline stages let a new word in while a result waits to be taken
module matrix4_vector_transform #(
    parameter int FRAC_BITS = mvt_pkg::MVT_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  mvt_pkg::mvt_in_word_t  req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output mvt_pkg::mvt_out_word_t rsp
);

    // pipeline handshake: each stage moves when the one after it can take it
    mvt_pkg::mvt_pipe_ctl_t ctl;
    logic prod_valid_reg;
    logic prod_valid_next;
    logic pair_valid_reg;
    logic pair_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic load_we;

    mvt_pkg::mvt_word_t matrix [mvt_pkg::MVT_ELEMS];
    mvt_pkg::mvt_word_t vec [mvt_pkg::MVT_DIM];
    mvt_pkg::mvt_word_t lane_m [mvt_pkg::MVT_DIM][mvt_pkg::MVT_DIM];
    mvt_pkg::mvt_pair_t pair_sum [mvt_pkg::MVT_DIM][2];

    always_comb
    begin
        ctl.out_en  = !rsp_valid_reg || rsp_ready;
        ctl.pair_en = !pair_valid_reg || ctl.out_en;
        ctl.prod_en = !prod_valid_reg || ctl.pair_en;

        prod_valid_next = ctl.prod_en
                        ? (req_valid && req.operation == mvt_pkg::OP_TRANSFORM)
                        : prod_valid_reg;
        pair_valid_next = ctl.pair_en ? prod_valid_reg : pair_valid_reg;
        rsp_valid_next  = ctl.out_en ? pair_valid_reg : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            pair_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            pair_valid_reg <= pair_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    assign req_ready = ctl.prod_en;
    assign rsp_valid = rsp_valid_reg;

    // loads write the store at acceptance, so later transforms see them
    assign load_we = req_valid && req_ready && req.operation == mvt_pkg::OP_LOAD;

    mvt_matrix_store u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (load_we),
        .col_index     (req.col_index),
        .row_index     (req.row_index),
        .element_value (req.element_value),
        .elem          (matrix)
    );

    assign vec[0] = req.vec_x;
    assign vec[1] = req.vec_y;
    assign vec[2] = req.vec_z;
    assign vec[3] = req.vec_w;

    // lane r takes row r of the matrix, i.e. element (c,r) of every column
    for (genvar r = 0; r < mvt_pkg::MVT_DIM; r++)
    begin : g_lane
        for (genvar c = 0; c < mvt_pkg::MVT_DIM; c++)
        begin : g_col
            assign lane_m[r][c] = matrix[c*mvt_pkg::MVT_DIM + r];
        end

        mvt_row_lane u_lane (
            .clk      (clk),
            .ctl      (ctl),
            .m_row    (lane_m[r]),
            .vec      (vec),
            .pair_sum (pair_sum[r])
        );
    end

    mvt_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk      (clk),
        .ctl      (ctl),
        .pair_sum (pair_sum),
        .out_word (rsp)
    );

`ifndef NO_ASSERTIONS
    // a load never enters the arithmetic pipeline
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.operation == mvt_pkg::OP_LOAD
        |=> !prod_valid_reg)
        else $error("load word entered the product stage");

    // an accepted transform always lands in the product stage
    a_transform_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.operation == mvt_pkg::OP_TRANSFORM
        |=> prod_valid_reg)
        else $error("accepted transform lost");

    // a result only leaves the output register once taken
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid_reg) |-> $past(rsp_ready))
        else $error("result dropped before being taken");

    // clip flag means at least one row sits at a saturation limit
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.saturated
        |-> (rsp.out_x == mvt_pkg::MVT_WORD_MAX || rsp.out_x == mvt_pkg::MVT_WORD_MIN
          || rsp.out_y == mvt_pkg::MVT_WORD_MAX || rsp.out_y == mvt_pkg::MVT_WORD_MIN
          || rsp.out_z == mvt_pkg::MVT_WORD_MAX || rsp.out_z == mvt_pkg::MVT_WORD_MIN
          || rsp.out_w == mvt_pkg::MVT_WORD_MAX || rsp.out_w == mvt_pkg::MVT_WORD_MIN))
        else $error("saturated set with no row at a limit");
`endif

endmodule

// ===== rtl/core/mvt_matrix_store.sv =====
// column-major 4x4 matrix register file, one element written per load word
module mvt_matrix_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  mvt_pkg::mvt_idx_t col_index,
    input  mvt_pkg::mvt_idx_t row_index,
    input  mvt_pkg::mvt_word_t element_value,
    output mvt_pkg::mvt_word_t elem [mvt_pkg::MVT_ELEMS]
);

    mvt_pkg::mvt_word_t elem_reg [mvt_pkg::MVT_ELEMS];

    // element (col,row) lives at col*4+row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mvt_pkg::MVT_ELEMS; i++)
            begin
                elem_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            elem_reg[{col_index, row_index}] <= element_value;
        end
    end

    assign elem = elem_reg;

endmodule

// ===== rtl/core/mvt_row_lane.sv =====
// one output row: four products, then two registered pair sums
module mvt_row_lane (
    input  logic                  clk,
    input  mvt_pkg::mvt_pipe_ctl_t ctl,
    input  mvt_pkg::mvt_word_t    m_row [mvt_pkg::MVT_DIM],
    input  mvt_pkg::mvt_word_t    vec [mvt_pkg::MVT_DIM],
    output mvt_pkg::mvt_pair_t    pair_sum [2]
);

    mvt_pkg::mvt_prod_t prod_reg [mvt_pkg::MVT_DIM];
    mvt_pkg::mvt_prod_t prod_next [mvt_pkg::MVT_DIM];
    mvt_pkg::mvt_pair_t pair_reg [2];
    mvt_pkg::mvt_pair_t pair_next [2];

    always_comb
    begin
        for (int c = 0; c < mvt_pkg::MVT_DIM; c++)
        begin
            prod_next[c] = mvt_pkg::MVT_PROD_BITS'(m_row[c])
                         * mvt_pkg::MVT_PROD_BITS'(vec[c]);
        end
        for (int p = 0; p < 2; p++)
        begin
            pair_next[p] = mvt_pkg::MVT_PAIR_BITS'(prod_reg[2*p])
                         + mvt_pkg::MVT_PAIR_BITS'(prod_reg[2*p+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.pair_en)
        begin
            pair_reg <= pair_next;
        end
    end

    assign pair_sum = pair_reg;

endmodule

// ===== rtl/core/mvt_merge.sv =====
// final row sums, fraction shift, saturation and merged clip flag
module mvt_merge #(
    parameter int FRAC_BITS = mvt_pkg::MVT_FRAC_BITS
) (
    input  logic                   clk,
    input  mvt_pkg::mvt_pipe_ctl_t ctl,
    input  mvt_pkg::mvt_pair_t     pair_sum [mvt_pkg::MVT_DIM][2],
    output mvt_pkg::mvt_out_word_t out_word
);

    localparam int W = mvt_pkg::MVT_WORD_BITS;
    localparam int S = mvt_pkg::MVT_SUM_BITS;

    mvt_pkg::mvt_sum_t     row_sum [mvt_pkg::MVT_DIM];
    mvt_pkg::mvt_sum_t     row_shift [mvt_pkg::MVT_DIM];
    mvt_pkg::mvt_word_t    row_word [mvt_pkg::MVT_DIM];
    logic                  clip_any;
    mvt_pkg::mvt_out_word_t out_word_next;
    mvt_pkg::mvt_out_word_t out_word_reg;

    always_comb
    begin
        clip_any = 1'b0;
        for (int r = 0; r < mvt_pkg::MVT_DIM; r++)
        begin
            row_sum[r]   = S'(pair_sum[r][0]) + S'(pair_sum[r][1]);
            row_shift[r] = row_sum[r] >>> FRAC_BITS;
            // in range when every bit above the word's sign bit matches it
            if (row_shift[r][S-1:W-1] == '0 || row_shift[r][S-1:W-1] == '1)
            begin
                row_word[r] = row_shift[r][W-1:0];
            end
            else
            begin
                clip_any    = 1'b1;
                row_word[r] = row_shift[r][S-1] ? mvt_pkg::MVT_WORD_MIN
                                                : mvt_pkg::MVT_WORD_MAX;
            end
        end
        out_word_next.out_x     = row_word[0];
        out_word_next.out_y     = row_word[1];
        out_word_next.out_z     = row_word[2];
        out_word_next.out_w     = row_word[3];
        out_word_next.saturated = clip_any;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_en)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_word = out_word_reg;

endmodule

// ===== bench/matrix4_vector_transform_tb.sv =====
// testbench for the 4x4 matrix times vector transform: directed and random words, scoreboard
module matrix4_vector_transform_tb;

    // cycles with no word moving on either channel before the run is called hung
    localparam int IDLE_LIMIT = 2000;
    // long receiver hold-off, long enough to fill the pipeline and stall the input
    localparam int HOLD_OFF_CYCLES = 200;
    // cycles to wait after the last expected result, for anything stray
    localparam int TAIL_CYCLES = 10;

    localparam mvt_pkg::mvt_word_t ONE_Q16 = 32'sh0001_0000;

    // bounds of a result row before it is clipped to a word
    localparam logic signed [71:0] ROW_MAX = 72'sd2147483647;
    localparam logic signed [71:0] ROW_MIN = -72'sd2147483648;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    mvt_pkg::mvt_in_word_t  req       = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    mvt_pkg::mvt_out_word_t rsp;

    // bench copy of the matrix, column-major, index col*4+row
    mvt_pkg::mvt_word_t     shadow_matrix [16] = '{default: '0};
    // products still owed by the block, oldest first
    mvt_pkg::mvt_out_word_t expected_results [$];

    int failures    = 0;
    int idle_cycles = 0;
    // set by a test to make the receiver hold off for a stretch of cycles
    int hold_len    = 0;
    // when set neither side inserts random gaps or stalls; a requested hold-off still applies
    bit no_idle     = 1'b0;

    matrix4_vector_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction: M * v with the exact four-term sum, floor shift by the
    // fraction bits, then clipping to a signed word
    // ------------------------------------------------------------------
    function automatic mvt_pkg::mvt_out_word_t transform_vector(
        input mvt_pkg::mvt_in_word_t w);
        mvt_pkg::mvt_out_word_t res;
        logic signed [71:0]     acc;
        logic signed [71:0]     scaled;
        mvt_pkg::mvt_word_t     comp [4];
        mvt_pkg::mvt_word_t     row_val [4];
        logic                   clipped;
        comp[0] = w.vec_x;
        comp[1] = w.vec_y;
        comp[2] = w.vec_z;
        comp[3] = w.vec_w;
        clipped = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            acc = '0;
            for (int c = 0; c < 4; c++)
                acc += $signed(shadow_matrix[c*4+r]) * $signed(comp[c]);
            scaled = acc >>> mvt_pkg::MVT_FRAC_BITS;
            if (scaled > ROW_MAX)
            begin
                row_val[r] = mvt_pkg::MVT_WORD_MAX;
                clipped    = 1'b1;
            end
            else if (scaled < ROW_MIN)
            begin
                row_val[r] = mvt_pkg::MVT_WORD_MIN;
                clipped    = 1'b1;
            end
            else
                row_val[r] = scaled[31:0];
        end
        res.out_x     = row_val[0];
        res.out_y     = row_val[1];
        res.out_z     = row_val[2];
        res.out_w     = row_val[3];
        res.saturated = clipped;
        return res;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: results are checked before the input word of the same edge
    // is folded in, so a load never leaks into an earlier product
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        mvt_pkg::mvt_out_word_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with none expected, actual %h", $time, rsp);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("out_x", want.out_x, rsp.out_x);
                report_field("out_y", want.out_y, rsp.out_y);
                report_field("out_z", want.out_z, rsp.out_z);
                report_field("out_w", want.out_w, rsp.out_w);
                report_field("saturated", 32'(want.saturated), 32'(rsp.saturated));
            end
        end
        if (rst_n && req_valid && req_ready)
        begin
            if (req.operation == mvt_pkg::OP_LOAD)
                shadow_matrix[{req.col_index, req.row_index}] = req.element_value;
            else
                expected_results.push_back(transform_vector(req));
        end
    end

    // watchdog: a run that stops moving words is a failure
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // receiver: random stalls, plus the long hold-off a test may ask for
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                rsp_ready <= 1'b0;
                hold_len--;
            end
            else if (stall_left > 0 && !no_idle)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready  <= 1'b1;
                stall_left = 0;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // word builders: the fields a word ignores carry random junk
    // ------------------------------------------------------------------
    function automatic mvt_pkg::mvt_in_word_t load_word(input mvt_pkg::mvt_idx_t col,
                                                        input mvt_pkg::mvt_idx_t row,
                                                        input mvt_pkg::mvt_word_t value);
        mvt_pkg::mvt_in_word_t w;
        w.operation     = mvt_pkg::OP_LOAD;
        w.col_index     = col;
        w.row_index     = row;
        w.element_value = value;
        w.vec_x         = $urandom;
        w.vec_y         = $urandom;
        w.vec_z         = $urandom;
        w.vec_w         = $urandom;
        return w;
    endfunction

    function automatic mvt_pkg::mvt_in_word_t transform_word(input mvt_pkg::mvt_word_t x,
                                                             input mvt_pkg::mvt_word_t y,
                                                             input mvt_pkg::mvt_word_t z,
                                                             input mvt_pkg::mvt_word_t v);
        mvt_pkg::mvt_in_word_t w;
        w.operation     = mvt_pkg::OP_TRANSFORM;
        w.col_index     = mvt_pkg::mvt_idx_t'($urandom);
        w.row_index     = mvt_pkg::mvt_idx_t'($urandom);
        w.element_value = $urandom;
        w.vec_x         = x;
        w.vec_y         = y;
        w.vec_z         = z;
        w.vec_w         = v;
        return w;
    endfunction

    // small values stay clear of clipping, full-range ones hit it, plus corner values
    function automatic mvt_pkg::mvt_word_t rand_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return mvt_pkg::mvt_word_t'(int'($urandom_range(0, 'h80000)) - 'h40000);
        if (roll < 85)
            return mvt_pkg::mvt_word_t'($urandom);
        case ($urandom_range(0, 6))
            0: return mvt_pkg::MVT_WORD_MAX;
            1: return mvt_pkg::MVT_WORD_MIN;
            2: return '0;
            3: return -1;
            4: return 1;
            5: return ONE_Q16;
            default: return -ONE_Q16;
        endcase
    endfunction

    function automatic mvt_pkg::mvt_in_word_t rand_item();
        if ($urandom_range(0, 99) < 25)
            return load_word(mvt_pkg::mvt_idx_t'($urandom), mvt_pkg::mvt_idx_t'($urandom),
                             rand_word());
        return transform_word(rand_word(), rand_word(), rand_word(), rand_word());
    endfunction

    // sender: optional gap, then hold the word until it is taken
    task automatic send_word(input mvt_pkg::mvt_in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // matrix is all zero after reset, so any vector gives zero
    task automatic test_cleared_matrix();
        send_word(transform_word(mvt_pkg::MVT_WORD_MAX, mvt_pkg::MVT_WORD_MIN, -1, ONE_Q16));
    endtask

    // identity on the diagonal passes extremes through unclipped
    task automatic test_identity_and_extremes();
        for (int i = 0; i < 4; i++)
            send_word(load_word(mvt_pkg::mvt_idx_t'(i), mvt_pkg::mvt_idx_t'(i), ONE_Q16));
        send_word(transform_word(mvt_pkg::MVT_WORD_MAX, mvt_pkg::MVT_WORD_MIN, -1, 1));
        // element in column 2, row 3 feeds only row 3, next to the diagonal (3,3)
        send_word(load_word(2, 3, 32'sh0003_0000));
        send_word(transform_word(ONE_Q16, -ONE_Q16, 32'sh0002_0000, 32'sh0000_8000));
    endtask

    // clipping both ways, the exact boundary, and flooring of negative sums
    task automatic test_saturation_and_rounding();
        send_word(load_word(0, 0, mvt_pkg::MVT_WORD_MAX));
        send_word(transform_word(mvt_pkg::MVT_WORD_MAX, '0, '0, '0));
        send_word(transform_word(mvt_pkg::MVT_WORD_MIN, '0, '0, '0));
        send_word(load_word(0, 0, mvt_pkg::MVT_WORD_MIN));
        send_word(transform_word(mvt_pkg::MVT_WORD_MIN, '0, '0, '0));
        // smallest positive element times -1 lsb floors to -1, times +1 lsb to 0
        send_word(load_word(1, 1, 1));
        send_word(transform_word('0, -1, '0, '0));
        send_word(transform_word('0, 1, '0, '0));
        // row 0 lands one above the largest word: must clip
        send_word(load_word(0, 0, ONE_Q16));
        send_word(load_word(1, 0, 1));
        send_word(transform_word(mvt_pkg::MVT_WORD_MAX, ONE_Q16, '0, '0));
        // four full products of the same sign overflow a 64-bit sum
        for (int c = 0; c < 4; c++)
            send_word(load_word(mvt_pkg::mvt_idx_t'(c), 0, mvt_pkg::MVT_WORD_MIN));
        send_word(transform_word(mvt_pkg::MVT_WORD_MIN, mvt_pkg::MVT_WORD_MIN,
                                 mvt_pkg::MVT_WORD_MIN, mvt_pkg::MVT_WORD_MIN));
        send_word(transform_word(mvt_pkg::MVT_WORD_MAX, mvt_pkg::MVT_WORD_MAX,
                                 mvt_pkg::MVT_WORD_MAX, mvt_pkg::MVT_WORD_MAX));
    endtask

    // matrix times matrix: full reload, then one transform per column of the right operand
    task automatic test_matrix_product();
        for (int rep = 0; rep < 6; rep++)
        begin
            for (int e = 0; e < 16; e++)
                send_word(load_word(mvt_pkg::mvt_idx_t'(e / 4), mvt_pkg::mvt_idx_t'(e % 4),
                                    rand_word()));
            for (int c = 0; c < 4; c++)
                send_word(transform_word(rand_word(), rand_word(), rand_word(), rand_word()));
        end
    endtask

    // receiver holds off while words keep coming, so the pipe fills and stalls the input
    task automatic test_output_hold_off();
        no_idle  = 1'b1;
        hold_len = HOLD_OFF_CYCLES;
        repeat (80)
            send_word(transform_word(rand_word(), rand_word(), rand_word(), rand_word()));
        no_idle = 1'b0;
    endtask

    // no gaps anywhere, loads right before transforms that must see them
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (50)
        begin
            send_word(load_word(mvt_pkg::mvt_idx_t'($urandom), mvt_pkg::mvt_idx_t'($urandom),
                                rand_word()));
            send_word(transform_word(rand_word(), rand_word(), rand_word(), rand_word()));
            send_word(rand_item());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_stream();
        repeat (950)
            send_word(rand_item());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_matrix();
        test_identity_and_extremes();
        test_saturation_and_rounding();
        test_matrix_product();
        test_output_hold_off();
        test_back_to_back();
        test_random_stream();

        req_valid <= 1'b0;
        // let the monitor fold in the last accepted word first
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mvt_pkg.sv
rtl/core/mvt_matrix_store.sv
rtl/core/mvt_row_lane.sv
rtl/core/mvt_merge.sv
rtl/core/matrix4_vector_transform.sv
bench/matrix4_vector_transform_tb.sv
